// ----- design/http_request_line_parser_defines.svh -----
// Assertion macros for the request-line parser RTL.
`ifndef HTTP_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop at each rising clk edge, skipped while rstn is low.
`define HRLP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hrlp assertion failed");
// Check prop at each rising clk edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hrlp assertion failed");
`else
`define HRLP_ASSERT(lbl, clk, rstn, prop)
`define HRLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/hrlp_pkg.sv -----
// Types, codes and character tables of the HTTP request-line parser.
package hrlp_pkg;

    localparam int BUF_LEN  = 1024;
    localparam int OFF_W    = 10;     // width of reported offsets
    localparam int LEN_W    = 11;     // width of lengths and the byte counter
    localparam int OUT_DATA_W = 88;   // 81 result bits padded to whole bytes
    localparam int OUT_PAD_W  = 7;

    localparam logic [LEN_W-1:0] BUF_LEN_C = LEN_W'(BUF_LEN);

    // candidate bit positions
    localparam int CAND_GET  = 0;
    localparam int CAND_POST = 1;
    localparam int CAND_HEAD = 2;
    localparam int CAND_ECHO = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [4:0] {
        PH_METHOD  = 5'b00001,
        PH_PATH    = 5'b00010,
        PH_VPREFIX = 5'b00100,
        PH_VBODY   = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        METH_NONE = 2'd0,
        METH_GET  = 2'd1,
        METH_POST = 2'd2,
        METH_HEAD = 2'd3
    } method_t;

    typedef enum logic [2:0] {
        CLS_ECHO      = 3'd0,
        CLS_NOT_FOUND = 3'd1,
        CLS_BAD_REQ   = 3'd2,
        CLS_FILE      = 3'd3,
        CLS_PAGE      = 3'd4
    } route_t;

    typedef struct packed {
        logic [LEN_W-1:0] request_length;
        logic [LEN_W-1:0] version_length;
        logic [OFF_W-1:0] version_start;
        logic             version_present;
        logic [LEN_W-1:0] params_length;
        logic [OFF_W-1:0] params_start;
        logic             params_present;
        logic [LEN_W-1:0] path_length;
        logic [OFF_W-1:0] path_start;
        method_t          method_code;
        route_t           route_class;
    } result_t;

    // "GET /echo "
    function automatic logic [7:0] echo_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = 8'h47;
            4'd1: c = 8'h45;
            4'd2: c = 8'h54;
            4'd3: c = 8'h20;
            4'd4: c = 8'h2F;
            4'd5: c = 8'h65;
            4'd6: c = 8'h63;
            4'd7: c = 8'h68;
            4'd8: c = 8'h6F;
            4'd9: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "GET "
    function automatic logic [7:0] get_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h47;
            3'd1: c = 8'h45;
            3'd2: c = 8'h54;
            3'd3: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "POST "
    function automatic logic [7:0] post_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h50;
            3'd1: c = 8'h4F;
            3'd2: c = 8'h53;
            3'd3: c = 8'h54;
            3'd4: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HEAD "
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h48;
            3'd1: c = 8'h45;
            3'd2: c = 8'h41;
            3'd3: c = 8'h44;
            3'd4: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HTTP"
    function automatic logic [7:0] http_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h48;
            2'd1: c = 8'h54;
            2'd2: c = 8'h54;
            2'd3: c = 8'h50;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/hrlp_core.sv -----
// Per-byte parse state of the request line and the result it yields.
module hrlp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           req_byte,
    input  logic                 last_byte,
    output hrlp_pkg::result_t    result
);

    localparam int LW = hrlp_pkg::LEN_W;
    localparam int OW = hrlp_pkg::OFF_W;

    logic [LW-1:0]        pos_reg, pos_next, u_pos;
    hrlp_pkg::phase_t     phase_reg, phase_next, u_phase;
    logic [3:0]           cand_reg, cand_next, u_cand;
    hrlp_pkg::method_t    method_reg, method_next, u_method;
    logic [OW-1:0]        pbegin_reg, pbegin_next, u_pbegin;
    logic [LW-1:0]        pcount_reg, pcount_next, u_pcount;
    logic [LW-1:0]        qoff_reg, qoff_next, u_qoff;
    logic                 qseen_reg, qseen_next, u_qseen;
    logic                 tilde_reg, tilde_next, u_tilde;
    logic                 dot_reg, dot_next, u_dot;
    logic                 haspath_reg, haspath_next, u_haspath;
    logic [LW-1:0]        vbegin_reg, vbegin_next, u_vbegin;
    logic [LW-1:0]        vcount_reg, vcount_next, u_vcount;
    logic                 vfound_reg, vfound_next, u_vfound;

    logic                 consume;
    logic [LW-1:0]        vk;

    assign consume = byte_accept && (pos_reg < hrlp_pkg::BUF_LEN_C);
    assign vk      = pos_reg - vbegin_reg;

    // state after this byte
    always_comb begin
        u_pos     = pos_reg;
        u_phase   = phase_reg;
        u_cand    = cand_reg;
        u_method  = method_reg;
        u_pbegin  = pbegin_reg;
        u_pcount  = pcount_reg;
        u_qoff    = qoff_reg;
        u_qseen   = qseen_reg;
        u_tilde   = tilde_reg;
        u_dot     = dot_reg;
        u_haspath = haspath_reg;
        u_vbegin  = vbegin_reg;
        u_vcount  = vcount_reg;
        u_vfound  = vfound_reg;
        if (consume) begin
            u_pos = pos_reg + LW'(1);
            if (pos_reg < LW'(10) && req_byte != hrlp_pkg::echo_char(pos_reg[3:0])) begin
                u_cand[hrlp_pkg::CAND_ECHO] = 1'b0;
            end
            case (phase_reg)
                hrlp_pkg::PH_METHOD: begin
                    if (pos_reg < LW'(4) && req_byte != hrlp_pkg::get_char(pos_reg[2:0])) begin
                        u_cand[hrlp_pkg::CAND_GET] = 1'b0;
                    end
                    if (pos_reg < LW'(5) && req_byte != hrlp_pkg::post_char(pos_reg[2:0])) begin
                        u_cand[hrlp_pkg::CAND_POST] = 1'b0;
                    end
                    if (pos_reg < LW'(5) && req_byte != hrlp_pkg::head_char(pos_reg[2:0])) begin
                        u_cand[hrlp_pkg::CAND_HEAD] = 1'b0;
                    end
                    if (pos_reg == LW'(3) && u_cand[hrlp_pkg::CAND_GET]) begin
                        u_method = hrlp_pkg::METH_GET;
                        u_phase  = hrlp_pkg::PH_PATH;
                        u_pbegin = OW'(4);
                    end else if (pos_reg >= LW'(4)) begin
                        if (u_cand[hrlp_pkg::CAND_POST]) begin
                            u_method = hrlp_pkg::METH_POST;
                        end else if (u_cand[hrlp_pkg::CAND_HEAD]) begin
                            u_method = hrlp_pkg::METH_HEAD;
                        end
                        if (u_method != hrlp_pkg::METH_NONE) begin
                            u_phase  = hrlp_pkg::PH_PATH;
                            u_pbegin = OW'(5);
                        end else begin
                            u_phase = hrlp_pkg::PH_DONE;
                        end
                    end
                end
                hrlp_pkg::PH_PATH: begin
                    if (req_byte == hrlp_pkg::CH_SPACE) begin
                        if (!qseen_reg) begin
                            u_pcount = pos_reg - {1'b0, pbegin_reg};
                        end
                        u_haspath = 1'b1;
                        u_vbegin  = pos_reg + LW'(1);
                        u_phase   = hrlp_pkg::PH_VPREFIX;
                    end else if (!qseen_reg) begin
                        if (req_byte == hrlp_pkg::CH_QMARK) begin
                            u_qseen  = 1'b1;
                            u_qoff   = pos_reg + LW'(1);
                            u_pcount = pos_reg - {1'b0, pbegin_reg};
                        end else if (req_byte == hrlp_pkg::CH_TILDE) begin
                            u_tilde = 1'b1;
                        end else if (req_byte == hrlp_pkg::CH_DOT) begin
                            u_dot = 1'b1;
                        end
                    end
                end
                hrlp_pkg::PH_VPREFIX: begin
                    if (vk > LW'(3) || req_byte != hrlp_pkg::http_char(vk[1:0])) begin
                        u_phase = hrlp_pkg::PH_DONE;
                    end else if (vk == LW'(3)) begin
                        u_phase = hrlp_pkg::PH_VBODY;
                    end
                end
                hrlp_pkg::PH_VBODY: begin
                    if (req_byte == hrlp_pkg::CH_CR || req_byte == hrlp_pkg::CH_LF) begin
                        u_vfound = 1'b1;
                        u_vcount = vk;
                        u_phase  = hrlp_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result built from the state after the final byte
    always_comb begin
        if (u_pos >= LW'(10) && u_cand[hrlp_pkg::CAND_ECHO]) begin
            result.route_class = hrlp_pkg::CLS_ECHO;
        end else if (!u_haspath) begin
            result.route_class = hrlp_pkg::CLS_NOT_FOUND;
        end else if (u_tilde) begin
            result.route_class = hrlp_pkg::CLS_BAD_REQ;
        end else if (u_dot) begin
            result.route_class = hrlp_pkg::CLS_FILE;
        end else begin
            result.route_class = hrlp_pkg::CLS_PAGE;
        end
        result.method_code     = u_method;
        result.path_start      = u_haspath ? u_pbegin : '0;
        result.path_length     = u_haspath ? u_pcount : '0;
        result.params_present  = u_haspath && u_qseen;
        result.params_start    = (u_haspath && u_qseen) ? u_qoff[OW-1:0] : '0;
        result.params_length   = (u_haspath && u_qseen) ?
                                 (u_vbegin - LW'(1) - u_qoff) : '0;
        result.version_present = u_vfound;
        result.version_start   = u_vfound ? u_vbegin[OW-1:0] : '0;
        result.version_length  = u_vfound ? u_vcount : '0;
        result.request_length  = u_pos;
    end

    // start over after the final byte
    always_comb begin
        if (byte_accept && last_byte) begin
            pos_next     = '0;
            phase_next   = hrlp_pkg::PH_METHOD;
            cand_next    = 4'b1111;
            method_next  = hrlp_pkg::METH_NONE;
            pbegin_next  = '0;
            pcount_next  = '0;
            qoff_next    = '0;
            qseen_next   = 1'b0;
            tilde_next   = 1'b0;
            dot_next     = 1'b0;
            haspath_next = 1'b0;
            vbegin_next  = '0;
            vcount_next  = '0;
            vfound_next  = 1'b0;
        end else begin
            pos_next     = u_pos;
            phase_next   = u_phase;
            cand_next    = u_cand;
            method_next  = u_method;
            pbegin_next  = u_pbegin;
            pcount_next  = u_pcount;
            qoff_next    = u_qoff;
            qseen_next   = u_qseen;
            tilde_next   = u_tilde;
            dot_next     = u_dot;
            haspath_next = u_haspath;
            vbegin_next  = u_vbegin;
            vcount_next  = u_vcount;
            vfound_next  = u_vfound;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= hrlp_pkg::PH_METHOD;
            cand_reg    <= 4'b1111;
            method_reg  <= hrlp_pkg::METH_NONE;
            pbegin_reg  <= '0;
            pcount_reg  <= '0;
            qoff_reg    <= '0;
            qseen_reg   <= 1'b0;
            tilde_reg   <= 1'b0;
            dot_reg     <= 1'b0;
            haspath_reg <= 1'b0;
            vbegin_reg  <= '0;
            vcount_reg  <= '0;
            vfound_reg  <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            method_reg  <= method_next;
            pbegin_reg  <= pbegin_next;
            pcount_reg  <= pcount_next;
            qoff_reg    <= qoff_next;
            qseen_reg   <= qseen_next;
            tilde_reg   <= tilde_next;
            dot_reg     <= dot_next;
            haspath_reg <= haspath_next;
            vbegin_reg  <= vbegin_next;
            vcount_reg  <= vcount_next;
            vfound_reg  <= vfound_next;
        end
    end

endmodule

// ----- design/http_request_line_parser.sv -----
// Latency: a result word appears on m_ the cycle after the word marked s_tlast is taken.
// Throughput: one request byte per cycle; s_tready drops only while a result word waits
// and m_tready is low, so the output register sets the pace.
// Each byte is parsed by one level of compares and counter updates into the parse state.
// Reset (aresetn low, synchronous) empties the output and returns the parser to
// method matching; no clearing pass is needed.
module http_request_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] req_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] route_class, [4:3] method_code, [14:5] path_start, [25:15] path_length,
    // [26] params_present, [36:27] params_start, [47:37] params_length,
    // [48] version_present, [58:49] version_start, [69:59] version_length,
    // [80:70] request_length, [87:81] zero
    output logic [hrlp_pkg::OUT_DATA_W-1:0] m_tdata
);

`include "http_request_line_parser_defines.svh"

    logic               s_accept;
    hrlp_pkg::result_t  core_result;
    hrlp_pkg::result_t  out_reg;
    logic               m_valid_reg, m_valid_next;

    // take a new byte whenever the output register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    hrlp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .req_byte    (s_tdata),
        .last_byte   (s_tlast),
        .result      (core_result)
    );

    // load a result on the final byte, drop the valid flag once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept && s_tlast) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the payload until the next result replaces it
    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {
        {hrlp_pkg::OUT_PAD_W{1'b0}},
        out_reg.request_length,
        out_reg.version_length,
        out_reg.version_start,
        out_reg.version_present,
        out_reg.params_length,
        out_reg.params_start,
        out_reg.params_present,
        out_reg.path_length,
        out_reg.path_start,
        out_reg.method_code,
        out_reg.route_class
    };

    `HRLP_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !m_valid_reg)
    `HRLP_ASSERT(a_ready_when_empty, aclk, aresetn, !m_valid_reg |-> s_tready)
    `HRLP_ASSERT(a_valid_from_last, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(s_tvalid && s_tready && s_tlast))
    `HRLP_ASSERT(a_class_in_range, aclk, aresetn,
        m_valid_reg |-> (out_reg.route_class == hrlp_pkg::CLS_ECHO ||
                         out_reg.route_class == hrlp_pkg::CLS_NOT_FOUND ||
                         out_reg.route_class == hrlp_pkg::CLS_BAD_REQ ||
                         out_reg.route_class == hrlp_pkg::CLS_FILE ||
                         out_reg.route_class == hrlp_pkg::CLS_PAGE))
    `HRLP_ASSERT(a_length_nonzero, aclk, aresetn,
        m_valid_reg |-> (out_reg.request_length != '0))

endmodule
